@@ design/mdsf_pkg.sv @@
// Shared types and constants for the missing-data scale factor unit.
// No dependencies; imported by every module of the block.
package mdsf_pkg;

  // Field widths fixed by the item format
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SAMPLE_W = 6;
  localparam int unsigned LOCUS_W  = 10;
  localparam int unsigned N_W      = 11;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned FACTOR_W = 27;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned BIT_W    = 6;
  localparam int unsigned STEP_W   = 5;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Constants of the result format
  localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 27'd65536;
  localparam logic [N_W-1:0]      N_RESET      = 11'd1024;
  localparam logic [STEP_W-1:0]   DIV_LAST_STEP = 5'd26;

  // Divider start request
  typedef struct packed {
    logic           start;
    logic [N_W-1:0] numer;
    logic [N_W-1:0] divisor;
  } div_req_t;

  // Divider result
  typedef struct packed {
    logic                done;
    logic [FACTOR_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ design/mdsf_map_ram.sv @@
// Bitmap store: one write port and two registered read ports, 64-bit words.
// Depends on mdsf_pkg for the word width.
module mdsf_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [mdsf_pkg::WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_a_i,
  input  logic [AW-1:0]              raddr_b_i,
  output logic [mdsf_pkg::WORD_W-1:0] rdata_a_o,
  output logic [mdsf_pkg::WORD_W-1:0] rdata_b_o
);
  import mdsf_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_a_q;
  logic [WORD_W-1:0] rdata_b_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read two words, data available in the following cycle
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ design/mdsf_div.sv @@
// Restoring divider, one quotient bit per cycle: (numer << 16) / divisor.
// Depends on mdsf_pkg for widths and the request/result structs.
module mdsf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mdsf_pkg::div_req_t req_i,
  output mdsf_pkg::div_rsp_t rsp_o
);
  import mdsf_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [N_W-1:0]      div_q, div_d;
  logic [N_W:0]        rem_q, rem_d;
  logic [FACTOR_W-1:0] quo_q, quo_d;
  logic [N_W:0]        rem_shift;

  // Load operands on start, else shift in the next dividend bit and try to subtract
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    step_d    = step_q;
    div_d     = div_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    rem_shift = {rem_q[N_W-1:0], quo_q[FACTOR_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      div_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = {req_i.numer, {FRAC_W{1'b0}}};
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, div_q}) begin
        rem_d = rem_shift - {1'b0, div_q};
        quo_d = {quo_q[FACTOR_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift;
        quo_d = {quo_q[FACTOR_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == DIV_LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Hold operands
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ design/missing_data_scale_factor_unit.sv @@
// Top level of the missing-data scale factor unit: sequencer, popcount, result register.
// Depends on mdsf_pkg, mdsf_map_ram and mdsf_div.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------------
//   in       | in_valid_i / in_ready_o     | kind_i, first_sample_i, second_sample_i, locus_i
//   out      | out_valid_o / out_ready_i   | scale_factor_o, all_missing_o
//   cfg      | cfg_we_i (no wait)          | cfg_wdata_i (total_loci)
//
// One request at a time. Mark: read, modify, write back. Clear: one map word written
// per cycle. Query of two samples: two map words read per cycle, then, unless the
// union count reaches total_loci, a 27-step divider. Query of one sample with itself:
// the unit factor, with no map read.
// After reset a clearing pass writes SAMPLES_MAX*WORDS words, one per cycle, with
// in_ready_o low. A stalled output holds its result while the next request is
// accepted; a finished query waits only if the output is still full.
module missing_data_scale_factor_unit #(
  parameter int unsigned LOCI_MAX    = 1024,
  parameter int unsigned SAMPLES_MAX = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mdsf_pkg::N_W-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mdsf_pkg::KIND_W-1:0]   kind_i,
  input  logic [mdsf_pkg::SAMPLE_W-1:0] first_sample_i,
  input  logic [mdsf_pkg::SAMPLE_W-1:0] second_sample_i,
  input  logic [mdsf_pkg::LOCUS_W-1:0]  locus_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mdsf_pkg::FACTOR_W-1:0] scale_factor_o,
  output logic                          all_missing_o
);
  import mdsf_pkg::*;

  localparam int unsigned WORDS = (LOCI_MAX + WORD_W - 1) / WORD_W;
  localparam int unsigned DEPTH = SAMPLES_MAX * WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CNT_W = AW + 1;
  localparam int unsigned CW    = $clog2(LOCI_MAX + 1);

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_MARK_RD = 8'b0000_0100,
    S_MARK_WR = 8'b0000_1000,
    S_CLEAR   = 8'b0001_0000,
    S_QUERY   = 8'b0010_0000,
    S_DIV     = 8'b0100_0000,
    S_PUSH    = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [N_W-1:0]      cfg_n_q, cfg_n_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic [WW-1:0]       rd_word_q, rd_word_d;
  logic [CW-1:0]       m_q, m_d;
  logic [CW-1:0]       limit_q, limit_d;
  logic [SAMPLE_W-1:0] s1_q, s1_d;
  logic [SAMPLE_W-1:0] s2_q, s2_d;
  logic [LOCUS_W-1:0]  locus_q, locus_d;
  logic                s1_ok_q, s1_ok_d;
  logic                s2_ok_q, s2_ok_d;
  logic                mark_ok_q, mark_ok_d;
  logic [FACTOR_W-1:0] res_factor_q, res_factor_d;
  logic                res_flag_q, res_flag_d;
  logic                out_valid_q, out_valid_d;
  logic [FACTOR_W-1:0] out_factor_q, out_factor_d;
  logic                out_flag_q, out_flag_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr_a;
  logic [AW-1:0]       ram_raddr_b;
  logic [WORD_W-1:0]   ram_rdata_a;
  logic [WORD_W-1:0]   ram_rdata_b;

  logic [WORD_W-1:0]   union_word;
  logic [WORD_W-1:0]   count_mask;
  logic [BIT_W:0]      pop;
  logic                issue;
  logic                decide;
  logic                accept;
  logic                push;
  logic [WW-1:0]       cnt_word;
  logic [WW-1:0]       locus_word;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Map a sample and word index to a store address
  function automatic logic [AW-1:0] addr_of(input logic [SAMPLE_W-1:0] sample,
                                            input logic [WW-1:0] word);
    int unsigned a;
    a = int'(sample) * WORDS + int'(word);
    return AW'(a);
  endfunction

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);
  assign cnt_word   = cnt_q[WW-1:0];
  assign locus_word = WW'(locus_q >> BIT_W);
  assign issue      = (state_q == S_QUERY) && (int'(cnt_q) < WORDS);
  assign decide     = (state_q == S_QUERY) && (int'(cnt_q) >= WORDS) && !rd_vld_q;
  assign push       = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  // Union of the two maps, masked to counted loci
  always_comb begin
    int lim;
    int base;
    lim        = int'(limit_q);
    base       = int'(rd_word_q) * WORD_W;
    union_word = (s1_ok_q ? ram_rdata_a : '0) | (s2_ok_q ? ram_rdata_b : '0);
    if (base >= lim) begin
      count_mask = '0;
    end else if (lim - base >= WORD_W) begin
      count_mask = '1;
    end else begin
      count_mask = ~({WORD_W{1'b1}} << BIT_W'(lim - base));
    end
    pop = (BIT_W + 1)'($countones(union_word & count_mask));
  end

  // Store port selection
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = addr_of(s1_q, cnt_word);
    ram_wdata   = '0;
    ram_raddr_a = addr_of(s1_q, cnt_word);
    ram_raddr_b = addr_of(s2_q, cnt_word);
    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
      end
      S_CLEAR: begin
        ram_we = s1_ok_q;
      end
      S_MARK_RD: begin
        ram_raddr_a = addr_of(s1_q, locus_word);
      end
      S_MARK_WR: begin
        ram_we    = mark_ok_q;
        ram_waddr = addr_of(s1_q, locus_word);
        ram_wdata = ram_rdata_a | (WORD_W'(1) << locus_q[BIT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  // Start the divider once the union count is known and below total_loci
  assign div_req.start   = decide && (int'(m_q) < int'(cfg_n_q));
  assign div_req.numer   = cfg_n_q;
  assign div_req.divisor = N_W'(int'(cfg_n_q) - int'(m_q));

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cfg_n_d      = cfg_we_i ? cfg_wdata_i : cfg_n_q;
    cnt_d        = cnt_q;
    rd_vld_d     = issue;
    rd_word_d    = cnt_word;
    m_d          = m_q;
    limit_d      = limit_q;
    s1_d         = s1_q;
    s2_d         = s2_q;
    locus_d      = locus_q;
    s1_ok_d      = s1_ok_q;
    s2_ok_d      = s2_ok_q;
    mark_ok_d    = mark_ok_q;
    res_factor_d = res_factor_q;
    res_flag_d   = res_flag_q;
    unique case (state_q)
      S_INIT: begin
        cnt_d = cnt_q + 1'b1;
        if (int'(cnt_q) == DEPTH - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          s1_d      = first_sample_i;
          s2_d      = second_sample_i;
          locus_d   = locus_i;
          s1_ok_d   = int'(first_sample_i) < SAMPLES_MAX;
          s2_ok_d   = int'(second_sample_i) < SAMPLES_MAX;
          mark_ok_d = (kind_i == KIND_MARK) && (int'(first_sample_i) < SAMPLES_MAX)
                      && (int'(locus_i) < LOCI_MAX);
          cnt_d     = '0;
          m_d       = '0;
          limit_d   = (int'(cfg_n_q) < LOCI_MAX) ? CW'(cfg_n_q) : CW'(LOCI_MAX);
          unique case (kind_i)
            KIND_MARK:  state_d = S_MARK_RD;
            KIND_CLEAR: state_d = S_CLEAR;
            KIND_QUERY: begin
              if (first_sample_i == second_sample_i) begin
                res_factor_d = FACTOR_ONE;
                res_flag_d   = 1'b0;
                state_d      = S_PUSH;
              end else begin
                state_d = S_QUERY;
              end
            end
            default:    state_d = S_MARK_WR;
          endcase
        end
      end
      S_MARK_RD: begin
        state_d = S_MARK_WR;
      end
      S_MARK_WR: begin
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (int'(cnt_q) == WORDS - 1) begin
          state_d = S_IDLE;
        end
      end
      S_QUERY: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          m_d = m_q + CW'(pop);
        end
        if (decide) begin
          if (div_req.start) begin
            state_d = S_DIV;
          end else begin
            res_factor_d = '0;
            res_flag_d   = 1'b1;
            state_d      = S_PUSH;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_factor_d = div_rsp.quotient;
          res_flag_d   = 1'b0;
          state_d      = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_factor_d = out_factor_q;
    out_flag_d   = out_flag_q;
    if (push) begin
      out_valid_d  = 1'b1;
      out_factor_d = res_factor_q;
      out_flag_d   = res_flag_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cfg_n_q     <= N_RESET;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_n_q     <= cfg_n_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold request and result payload
  always_ff @(posedge clk_i) begin
    rd_word_q    <= rd_word_d;
    m_q          <= m_d;
    limit_q      <= limit_d;
    s1_q         <= s1_d;
    s2_q         <= s2_d;
    locus_q      <= locus_d;
    s1_ok_q      <= s1_ok_d;
    s2_ok_q      <= s2_ok_d;
    mark_ok_q    <= mark_ok_d;
    res_factor_q <= res_factor_d;
    res_flag_q   <= res_flag_d;
    out_factor_q <= out_factor_d;
    out_flag_q   <= out_flag_d;
  end

  mdsf_map_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  mdsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign scale_factor_o = out_factor_q;
  assign all_missing_o  = out_flag_q;

endmodule

@@ design/mdsf_checker.sv @@
// Port-level checks for the missing-data scale factor unit, bound to the top level.
// Depends on mdsf_pkg for widths and the unit-factor constant.
module mdsf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mdsf_pkg::FACTOR_W-1:0] scale_factor_o,
  input logic                          all_missing_o
);
  import mdsf_pkg::*;

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scale_factor_o)
    && $stable(all_missing_o))
    else $error("stalled result changed");

  // Flagged result carries a zero factor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_missing_o |-> scale_factor_o == '0)
    else $error("flagged result with nonzero factor");

  // Unflagged factor is at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !all_missing_o |-> scale_factor_o >= FACTOR_ONE)
    else $error("factor below one");

  // Not ready in the cycle after each accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken in back-to-back cycles");

  // No request taken while the clearing pass starts
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("ready during clearing pass");

endmodule

bind missing_data_scale_factor_unit mdsf_checker u_mdsf_checker (.*);

@@ dv/mdsf_checker.sv @@
// Scoreboard for the missing-data scale factor unit: tracks per-sample missing-locus maps,
// predicts each pair factor and compares it with the result channel.
// Depends on mdsf_pkg.
module mdsf_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mdsf_pkg::N_W-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mdsf_pkg::KIND_W-1:0]   kind_i,
  input  logic [mdsf_pkg::SAMPLE_W-1:0] first_sample_i,
  input  logic [mdsf_pkg::SAMPLE_W-1:0] second_sample_i,
  input  logic [mdsf_pkg::LOCUS_W-1:0]  locus_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mdsf_pkg::FACTOR_W-1:0] scale_factor_i,
  input  logic                          all_missing_i,
  output int                            error_count_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            flagged_o
);
  import mdsf_pkg::*;

  localparam int unsigned LOCI    = 1024;
  localparam int unsigned SAMPLES = 64;
  localparam longint unsigned FACTOR_SAT = (64'd1 << FACTOR_W) - 1;

  typedef struct packed {
    logic [FACTOR_W-1:0] scale_factor;
    logic                all_missing;
  } factor_t;

  logic [LOCI-1:0] missing_bits [SAMPLES];
  logic [N_W-1:0]  total_loci;
  factor_t         expected_factors [$];
  factor_t         oldest;

  // Compute N/(N-M) for a pair, M counted over loci below min(N, LOCI)
  function automatic factor_t pair_factor(input logic [SAMPLE_W-1:0] a,
                                          input logic [SAMPLE_W-1:0] b);
    logic [LOCI-1:0] union_bits;
    int unsigned     limit;
    int unsigned     count;
    longint unsigned quot;
    factor_t         r;
    r = '0;
    if (a == b) begin
      r.scale_factor = FACTOR_ONE;
      return r;
    end
    limit = (total_loci < LOCI) ? total_loci : LOCI;
    union_bits = missing_bits[a] | missing_bits[b];
    count = 0;
    for (int i = 0; i < limit; i++) count += union_bits[i];
    if (count >= total_loci) begin
      r.all_missing = 1'b1;
    end else begin
      quot = (64'(total_loci) << FRAC_W) / 64'(total_loci - count);
      if (quot > FACTOR_SAT) quot = FACTOR_SAT;
      r.scale_factor = quot[FACTOR_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (missing_bits[i]) missing_bits[i] = '0;
      total_loci = N_RESET;
      expected_factors.delete();
      error_count_o = 0;
      pending_o     = 0;
      checked_o     = 0;
      flagged_o     = 0;
    end else begin
      if (cfg_we_i) total_loci = cfg_wdata_i;

      // Compare the result against the oldest prediction before taking the new request
      if (out_valid_i && out_ready_i) begin
        if (expected_factors.size() == 0) begin
          $error("unexpected result: scale_factor %0d all_missing %0d",
                 scale_factor_i, all_missing_i);
          error_count_o++;
        end else begin
          oldest = expected_factors.pop_front();
          if (scale_factor_i !== oldest.scale_factor) begin
            $error("scale_factor: expected %0d, got %0d", oldest.scale_factor, scale_factor_i);
            error_count_o++;
          end
          if (all_missing_i !== oldest.all_missing) begin
            $error("all_missing: expected %0d, got %0d", oldest.all_missing, all_missing_i);
            error_count_o++;
          end
          checked_o++;
          if (oldest.all_missing) flagged_o++;
        end
      end

      // Advance the map model with the accepted request
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_MARK:  missing_bits[first_sample_i][locus_i] = 1'b1;
          KIND_CLEAR: missing_bits[first_sample_i] = '0;
          KIND_QUERY: expected_factors.push_back(pair_factor(first_sample_i, second_sample_i));
          default: ;
        endcase
      end
      pending_o = expected_factors.size();
    end
  end

endmodule

@@ dv/tb_missing_data_scale_factor_unit.sv @@
// Testbench top for the missing-data scale factor unit: clock, reset, request and
// result traffic, total_loci writes and the verdict.
// Depends on mdsf_pkg, missing_data_scale_factor_unit and mdsf_scoreboard.
module tb_missing_data_scale_factor_unit;
  import mdsf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned PHASE_REQUESTS  = 143;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 6000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [N_W-1:0]      cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   kind;
  logic [SAMPLE_W-1:0] first_sample;
  logic [SAMPLE_W-1:0] second_sample;
  logic [LOCUS_W-1:0]  locus;
  logic                out_valid;
  logic                out_ready;
  logic [FACTOR_W-1:0] scale_factor;
  logic                all_missing;

  int errors, pending, checked, flagged;
  int unsigned sent, loci_writes, burst_left, stall_cycles = 0;
  logic        gaps_on, hold_cue, hold_done;
  logic [N_W-1:0] cur_total;
  logic [N_W-1:0] loci_plan [PHASES] = '{11'd1024, 11'd8, 11'd64, 11'd1, 11'd2047,
                                         11'd300, 11'd3, 11'd1000, 11'd24, 11'd512};

  always #5 clk = ~clk;

  missing_data_scale_factor_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (kind),
    .first_sample_i  (first_sample),
    .second_sample_i (second_sample),
    .locus_i         (locus),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .scale_factor_o  (scale_factor),
    .all_missing_o   (all_missing)
  );

  mdsf_scoreboard u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .kind_i          (kind),
    .first_sample_i  (first_sample),
    .second_sample_i (second_sample),
    .locus_i         (locus),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .scale_factor_i  (scale_factor),
    .all_missing_i   (all_missing),
    .error_count_o   (errors),
    .pending_o       (pending),
    .checked_o       (checked),
    .flagged_o       (flagged)
  );

  // Offer one request, with a random gap between bursts when gaps are on, and hold it until accepted
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [SAMPLE_W-1:0] a,
                              input logic [SAMPLE_W-1:0] b, input logic [LOCUS_W-1:0] l);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid      <= 1'b1;
    kind          <= k;
    first_sample  <= a;
    second_sample <= b;
    locus         <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted factor has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Write total_loci once the unit has gone quiet
  task automatic set_total(input logic [N_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_total = value;
    loci_writes++;
  endtask

  // Favor a few samples so their maps fill up and unions reach every locus
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SAMPLE_W'($urandom_range(0, 3));
    if (r < 85) return SAMPLE_W'(62 + $urandom_range(0, 1));
    return SAMPLE_W'($urandom_range(0, 63));
  endfunction

  task automatic random_request();
    int unsigned         pick;
    int unsigned         span;
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [LOCUS_W-1:0]  l;
    logic [KIND_W-1:0]   k;
    a = pick_sample();
    b = ($urandom_range(0, 9) == 0) ? a : pick_sample();
    span = (cur_total == 0) ? 1 : ((cur_total > 1024) ? 1024 : cur_total);
    l = ($urandom_range(0, 3) != 0) ? LOCUS_W'($urandom_range(0, span - 1))
                                    : LOCUS_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 48)      k = KIND_MARK;
    else if (pick < 56) k = KIND_CLEAR;
    else if (pick < 93) k = KIND_QUERY;
    else                k = KIND_UNUSED;
    send_request(k, a, b, l);
  endtask

  // Receiver: stretches of mixed stall patterns, plus one long hold on cue
  initial begin
    int unsigned span;
    int unsigned mode;
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      span = $urandom_range(10, 80);
      mode = $urandom_range(0, 3);
      if (hold_cue && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
        hold_done = 1'b1;
      end else begin
        for (int k = 0; k < span; k++) begin
          @(negedge clk);
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= k[0];
          endcase
        end
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("tb_missing_data_scale_factor_unit: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    in_valid      = 1'b0;
    kind          = KIND_MARK;
    first_sample  = '0;
    second_sample = '0;
    locus         = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    gaps_on       = 1'b1;
    hold_cue      = 1'b0;
    burst_left    = 0;
    sent          = 0;
    loci_writes   = 0;
    cur_total     = N_RESET;
    rst_n         = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    // Hold until the clearing pass after reset is over
    while (!in_ready) @(negedge clk);

    // Directed: identical pair, empty maps, extreme samples and loci, unused kind
    send_request(KIND_QUERY, 6'd0, 6'd0, 10'd0);
    send_request(KIND_QUERY, 6'd0, 6'd63, 10'd0);
    send_request(KIND_MARK, 6'd0, 6'd0, 10'd0);
    send_request(KIND_MARK, 6'd0, 6'd63, 10'd1023);
    send_request(KIND_MARK, 6'd63, 6'd0, 10'd512);
    send_request(KIND_MARK, 6'd63, 6'd0, 10'd0);
    send_request(KIND_QUERY, 6'd0, 6'd63, 10'd1023);
    send_request(KIND_QUERY, 6'd63, 6'd0, 10'd0);
    send_request(KIND_UNUSED, 6'd63, 6'd5, 10'd100);
    send_request(KIND_QUERY, 6'd63, 6'd5, 10'd0);
    send_request(KIND_CLEAR, 6'd63, 6'd0, 10'd0);
    send_request(KIND_QUERY, 6'd0, 6'd63, 10'd0);
    send_request(KIND_MARK, 6'd5, 6'd0, 10'd7);
    send_request(KIND_QUERY, 6'd5, 6'd5, 10'd0);
    // Marks at and beyond N are stored but not counted
    set_total(11'd16);
    send_request(KIND_MARK, 6'd63, 6'd0, 10'd15);
    send_request(KIND_MARK, 6'd63, 6'd0, 10'd16);
    send_request(KIND_QUERY, 6'd0, 6'd63, 10'd0);
    // Zero loci flags every distinct pair; one locus flags a marked union
    set_total(11'd0);
    send_request(KIND_QUERY, 6'd0, 6'd1, 10'd0);
    send_request(KIND_QUERY, 6'd1, 6'd1, 10'd0);
    set_total(11'd1);
    send_request(KIND_QUERY, 6'd0, 6'd2, 10'd0);
    set_total(11'd2047);
    send_request(KIND_QUERY, 6'd0, 6'd63, 10'd0);

    // Random phases, one loci setting each
    for (int p = 0; p < PHASES; p++) begin
      set_total(loci_plan[p]);
      gaps_on = (p != 2 && p != 6);
      if (p == 2) hold_cue = 1'b1;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (p == 4 && i == 70) wait_drained();
        random_request();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d requests over %0d total_loci settings; %0d factors checked, %0d all-missing",
             sent, loci_writes, checked, flagged);
    if (errors == 0) begin
      $display("tb_missing_data_scale_factor_unit: done, clean");
    end else begin
      $display("tb_missing_data_scale_factor_unit: done, errors");
    end
    $finish;
  end

endmodule
